FILE: rtl/core/sparse_matrix_entry_store_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse matrix entry store
// Shared property forms so every check reports the same way.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_ENTRY_STORE_MACROS_SVH
`define SPARSE_MATRIX_ENTRY_STORE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define SMES_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define SMES_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define SMES_ASSERT_NEXT_NR(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/smes_pkg.sv
// ----------------------------------------------------------------------------
// smes_pkg
// Types, constants and helpers shared by the sparse matrix entry store.
// ----------------------------------------------------------------------------
package smes_pkg;

    // Default table depth
    localparam int CAPACITY_DEF = 64;

    // Matrix bounds; coord_ok clamps the in-use registers to these
    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int LIM_W    = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;
    localparam logic [CFG_DATA_W-1:0] ROWS_IN_USE_RST = 9'd256;
    localparam logic [CFG_DATA_W-1:0] COLS_IN_USE_RST = 9'd256;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        row_index;
        logic [7:0]        col_index;
        logic signed [31:0] write_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic              in_range;
        logic              full_drop;
    } out_t;

    // One table slot
    typedef struct packed {
        logic              valid;
        logic [7:0]        row;
        logic [7:0]        col;
        logic signed [31:0] value;
    } entry_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] rows_in_use;
        logic [CFG_DATA_W-1:0] cols_in_use;
    } cfg_t;

    typedef struct packed {
        logic match;
        logic free;
    } cmp_res_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } ctrl_status_t;

    // Coordinate check against min(register, bound)
    function automatic logic coord_ok(logic [7:0] idx, logic [CFG_DATA_W-1:0] lim_reg,
                                      logic [LIM_W-1:0] bound);
        logic [LIM_W-1:0] reg_ext;
        logic [LIM_W-1:0] lim;
        reg_ext = {{(LIM_W-CFG_DATA_W){1'b0}}, lim_reg};
        lim     = (reg_ext < bound) ? reg_ext : bound;
        return {{(LIM_W-8){1'b0}}, idx} < lim;
    endfunction

endpackage

FILE: rtl/core/smes_table.sv
// ----------------------------------------------------------------------------
// smes_table
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smes_table #(
    parameter int CAPACITY = smes_pkg::CAPACITY_DEF,
    parameter int AW       = 6
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  smes_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output smes_pkg::entry_t rd_data
);
    import smes_pkg::*;

    entry_t mem [CAPACITY];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/smes_cmp.sv
// ----------------------------------------------------------------------------
// smes_cmp
// Shared coordinate comparator, applied to one table slot per cycle.
// ----------------------------------------------------------------------------
module smes_cmp (
    input  smes_pkg::entry_t   entry,
    input  logic [7:0]         key_row,
    input  logic [7:0]         key_col,
    output smes_pkg::cmp_res_t res
);
    import smes_pkg::*;

    // Hit on a live slot with both coordinates equal; free on a dead slot
    always_comb begin
        res.match = entry.valid && (entry.row == key_row) && (entry.col == key_col);
        res.free  = !entry.valid;
    end

endmodule

FILE: rtl/core/smes_ctrl.sv
// ----------------------------------------------------------------------------
// smes_ctrl
// Sequencer: clears the table after reset, scans it one slot a cycle per
// in-range request, applies the update and holds the result beat.
// ----------------------------------------------------------------------------
module smes_ctrl #(
    parameter int CAPACITY = smes_pkg::CAPACITY_DEF,
    parameter int AW       = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  smes_pkg::cfg_t         cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  smes_pkg::in_t          s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output smes_pkg::out_t         m_data,
    output smes_pkg::ctrl_status_t status
);
    import smes_pkg::*;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
    localparam logic [ST_W-1:0] ST_SCAN  = 3'd2;
    localparam logic [ST_W-1:0] ST_ACT   = 3'd3;
    localparam logic [ST_W-1:0] ST_FIN   = 3'd4;

    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    // Control state
    logic [ST_W-1:0] state_reg, state_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic            issue_done_reg, issue_done_next;
    logic            cmp_v_reg, cmp_v_next;
    logic            hit_reg, hit_next;
    logic            free_found_reg, free_found_next;
    logic            m_valid_reg, m_valid_next;

    // Payload
    logic [AW-1:0]   cmp_addr_reg, cmp_addr_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [31:0]     hit_value_reg, hit_value_next;
    in_t             req_reg, req_next;
    out_t            res_reg, res_next;
    out_t            m_data_reg, m_data_next;

    // Table port
    logic            tbl_wr_en;
    logic [AW-1:0]   tbl_wr_addr;
    entry_t          tbl_wr_data;
    entry_t          tbl_rd_data;
    cmp_res_t        cr;
    logic            coord_in;

    smes_table #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (addr_reg),
        .rd_data (tbl_rd_data)
    );

    smes_cmp u_cmp (
        .entry   (tbl_rd_data),
        .key_row (req_reg.row_index),
        .key_col (req_reg.col_index),
        .res     (cr)
    );

    // Range check on the incoming beat
    assign coord_in = coord_ok(s_data.row_index, cfg.rows_in_use, LIM_W'(MAX_ROWS)) &&
                      coord_ok(s_data.col_index, cfg.cols_in_use, LIM_W'(MAX_COLS));

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        cmp_v_next      = cmp_v_reg;
        cmp_addr_next   = cmp_addr_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        hit_value_next  = hit_value_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = slot_reg;
        tbl_wr_data     = '0;

        // Result beat taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = addr_reg;
                addr_next   = addr_reg + 1'b1;
                if (addr_reg == LAST) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next        = s_data;
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    cmp_v_next      = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    if (coord_in) begin
                        state_next = ST_SCAN;
                    end else begin
                        res_next   = '0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue the next read; the compare of that slot follows in the next cycle
                cmp_v_next    = !issue_done_reg;
                cmp_addr_next = addr_reg;
                if (!issue_done_reg) begin
                    addr_next = addr_reg + 1'b1;
                    if (addr_reg == LAST) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (cmp_v_reg) begin
                    if (cr.match) begin
                        hit_next       = 1'b1;
                        slot_next      = cmp_addr_reg;
                        hit_value_next = tbl_rd_data.value;
                        cmp_v_next     = 1'b0;
                        state_next     = ST_ACT;
                    end else begin
                        if (cr.free && !free_found_reg) begin
                            free_found_next = 1'b1;
                            slot_next       = cmp_addr_reg;
                        end
                        if (cmp_addr_reg == LAST) begin
                            cmp_v_next = 1'b0;
                            state_next = ST_ACT;
                        end
                    end
                end
            end
            ST_ACT: begin
                res_next.in_range   = 1'b1;
                res_next.read_value = ((req_reg.req_type == REQ_READ) && hit_reg) ?
                                      hit_value_reg : '0;
                res_next.full_drop  = (req_reg.req_type == REQ_WRITE) && !hit_reg &&
                                      (req_reg.write_value != 0) && !free_found_reg;
                // Update, delete or insert
                tbl_wr_en = (req_reg.req_type == REQ_WRITE) &&
                            (hit_reg || ((req_reg.write_value != 0) && free_found_reg));
                tbl_wr_addr       = slot_reg;
                tbl_wr_data.valid = (req_reg.write_value != 0);
                tbl_wr_data.row   = req_reg.row_index;
                tbl_wr_data.col   = req_reg.col_index;
                tbl_wr_data.value = req_reg.write_value;
                state_next        = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            cmp_v_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            cmp_v_reg      <= cmp_v_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmp_addr_reg  <= cmp_addr_next;
        slot_reg      <= slot_next;
        hit_value_reg <= hit_value_next;
        req_reg       <= req_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.busy     = (state_reg == ST_SCAN) || (state_reg == ST_ACT) ||
                             (state_reg == ST_FIN);

endmodule

FILE: rtl/core/sparse_matrix_entry_store.sv
// ----------------------------------------------------------------------------
// sparse_matrix_entry_store
// Bounded table of (row, column, value) entries for a sparse matrix.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request beat (read or write of one element), valid/ready.
//   m_ channel: exactly one result beat per request, valid/ready, in order.
//   cfg port:   cfg_we/cfg_addr/cfg_wdata set rows_in_use and cols_in_use;
//               write only while no request is in flight.
// Timing:
//   A request scans the table one slot a cycle through the single read port
//   of the entry memory. A hit in slot j ends the scan at that slot; a miss
//   scans every slot. A rejected coordinate skips the scan and goes straight
//   to the result stage. s_ready returns in the cycle the result is loaded
//   into the output register.
// Reset:
//   Registers return to 256. A clearing pass marks every slot empty;
//   s_ready stays low until it finishes.
// Stall:
//   A result waiting on m_ready is held in the output register; the next
//   request is still accepted and waits at its end for the register to free.
// ----------------------------------------------------------------------------
`include "sparse_matrix_entry_store_macros.svh"

module sparse_matrix_entry_store #(
    parameter int CAPACITY = smes_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [smes_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [smes_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  smes_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output smes_pkg::out_t                  m_data
);
    import smes_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CFG_DATA_W-1:0] rows_reg, rows_next;
    logic [CFG_DATA_W-1:0] cols_reg, cols_next;
    cfg_t                  cfg;
    ctrl_status_t          st;

    // Configuration writes
    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_ROWS_IN_USE: rows_next = cfg_wdata;
                REG_COLS_IN_USE: cols_next = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_IN_USE_RST;
            cols_reg <= COLS_IN_USE_RST;
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    assign cfg.rows_in_use = rows_reg;
    assign cfg.cols_in_use = cols_reg;

    smes_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .status  (st)
    );

    // Checks
    `SMES_ASSERT_NEXT_NR(a_reset_blocks, aclk, !aresetn, !s_ready, "ready after reset")
    `SMES_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "busy take")
    `SMES_ASSERT_IMPL(a_busy_not_ready, aclk, aresetn, st.clearing || st.busy, !s_ready, "ready busy")
    `SMES_ASSERT_IMPL(a_drop_in_range, aclk, aresetn, m_valid && m_data.full_drop, m_data.in_range, "bad drop")

endmodule
